### rtl/spm_pkg.sv
// spm_pkg: constants and codes for the substring position matcher
// register indexes, match mode codes and default sizes; no dependencies
`default_nettype none

package spm_pkg;

   // default sizes for the top-level parameters
   localparam int MAX_PATTERN_DEF   = 16;
   localparam int POSITION_BITS_DEF = 16;

   // pattern storage is fixed by the two 64-bit pattern words
   localparam int PATTERN_SLOTS = 16;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 5;
   localparam int MODE_W        = 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 64;
   localparam int POS_OUT_W     = 16;
   localparam int RSP_DATA_W    = 24;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW_WORD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH_WORD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MATCH_MODE        = 2'd3;

   // match mode codes; the unused code behaves as first occurrence
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUFFIX = 2'd2;

endpackage : spm_pkg

`default_nettype wire

### rtl/substring_position_matcher_unit.sv
// substring_position_matcher_unit: streaming naive substring search over text bytes
// compares a sliding byte window with a configured pattern; uses spm_pkg
//
// timing: a request is evaluated in the cycle it is taken; the result is in the
// output register in the cycle after the end-of-text request is taken
// throughput: one request per cycle (stalled while rsp waits), single parallel window compare
// reset: synchronous, clears window, byte counter, hit state, config registers and output valid
`default_nettype none

module substring_position_matcher_unit
   import spm_pkg::*;
#(
   parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // [7:0] text_byte
   input  wire logic                   req_tuser,   // [0] byte_present
   input  wire logic                   req_tlast,   // end_of_text

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [0] found, [16:1] match_position,
                                                    // [17] length_overflow, [23:18] zero

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CNT_W = POSITION_BITS + 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);
   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << POSITION_BITS;

   // configuration registers
   logic [LEN_W-1:0]      pattern_length_ff;
   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [MODE_W-1:0]     match_mode_ff;

   // text state
   logic [BYTE_W-1:0]        window_ff [MAX_PATTERN];
   logic [BYTE_W-1:0]        window_in [MAX_PATTERN];
   logic [CNT_W-1:0]         bytes_seen_ff, bytes_seen_in;
   logic                     first_hit_ff, first_hit_in;
   logic [POSITION_BITS-1:0] first_pos_ff, first_pos_in;
   logic                     last_hit_ff, last_hit_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [POS_OUT_W-1:0]     position_ff, position_in;
   logic                     overflow_ff, overflow_in;

   logic                     req_fire;
   logic                     byte_take;
   logic [LEN_W-1:0]         len_eff;
   logic [BYTE_W-1:0]        pattern_bytes [PATTERN_SLOTS];
   logic                     window_match;
   logic                     window_hit;
   logic [CNT_W-1:0]         start_offset;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign byte_take  = req_fire && req_tuser;
   assign csr_ready  = 1'b1;

   assign len_eff = (pattern_length_ff > MAX_LEN) ? MAX_LEN : pattern_length_ff;

   always_comb begin
      for (int i = 0; i < PATTERN_SLOTS / 2; i++) begin
         pattern_bytes[i]                     = pattern_low_ff[BYTE_W*i +: BYTE_W];
         pattern_bytes[i + PATTERN_SLOTS / 2] = pattern_high_ff[BYTE_W*i +: BYTE_W];
      end
   end

   // window after the new byte shifts in, entry 0 newest
   always_comb begin
      window_in[0] = byte_take ? req_tdata : window_ff[0];
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = byte_take ? window_ff[j-1] : window_ff[j];
      end
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      if (byte_take && (bytes_seen_ff < COUNT_LIMIT)) begin
         bytes_seen_in = bytes_seen_ff + CNT_W'(1);
      end
   end

   // window entry j must equal pattern byte len-1-j for every j below len
   always_comb begin
      logic [3:0] pat_idx;
      window_match = 1'b1;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pat_idx = 4'(len_eff - LEN_W'(j) - LEN_W'(1));
         if ((LEN_W'(j) < len_eff) && (window_in[j] != pattern_bytes[pat_idx])) begin
            window_match = 1'b0;
         end
      end
   end

   assign window_hit   = window_match && (len_eff != '0) &&
                         (bytes_seen_in >= CNT_W'(len_eff));
   assign start_offset = bytes_seen_in - CNT_W'(len_eff);

   always_comb begin
      first_hit_in = first_hit_ff;
      first_pos_in = first_pos_ff;
      last_hit_in  = last_hit_ff;
      if (byte_take) begin
         last_hit_in = window_hit;
         // once the counter saturates a start offset can no longer be recorded
         if (window_hit && !first_hit_ff && !bytes_seen_in[POSITION_BITS]) begin
            first_hit_in = 1'b1;
            first_pos_in = start_offset[POSITION_BITS-1:0];
         end
      end
   end

   // outcome of the selected test on the updated state
   always_comb begin
      logic [POSITION_BITS-1:0] pos;
      pos         = '0;
      found_in    = 1'b0;
      overflow_in = bytes_seen_in[POSITION_BITS];
      priority if (len_eff == '0) begin
         found_in = 1'b1;
      end else if (match_mode_ff == MODE_PREFIX) begin
         found_in = first_hit_in && (first_pos_in == '0);
      end else if (match_mode_ff == MODE_SUFFIX) begin
         found_in = last_hit_in;
         if (last_hit_in) begin
            pos = start_offset[POSITION_BITS] ? '1 : start_offset[POSITION_BITS-1:0];
         end
      end else begin
         found_in = first_hit_in;
         pos      = first_hit_in ? first_pos_in : '0;
      end
      position_in = POS_OUT_W'(pos);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         match_mode_ff     <= MODE_FIRST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PATTERN_LENGTH:    pattern_length_ff <= csr_data[LEN_W-1:0];
            REG_PATTERN_LOW_WORD:  pattern_low_ff    <= csr_data;
            REG_PATTERN_HIGH_WORD: pattern_high_ff   <= csr_data;
            REG_MATCH_MODE:        match_mode_ff     <= csr_data[MODE_W-1:0];
            default:               pattern_length_ff <= pattern_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_PATTERN; j++) begin
            window_ff[j] <= '0;
         end
         bytes_seen_ff <= '0;
         first_hit_ff  <= 1'b0;
         first_pos_ff  <= '0;
         last_hit_ff   <= 1'b0;
      end else if (req_fire && req_tlast) begin
         // text finished: clear for the next one
         for (int j = 0; j < MAX_PATTERN; j++) begin
            window_ff[j] <= '0;
         end
         bytes_seen_ff <= '0;
         first_hit_ff  <= 1'b0;
         first_pos_ff  <= '0;
         last_hit_ff   <= 1'b0;
      end else begin
         window_ff     <= window_in;
         bytes_seen_ff <= bytes_seen_in;
         first_hit_ff  <= first_hit_in;
         first_pos_ff  <= first_pos_in;
         last_hit_ff   <= last_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         found_ff    <= found_in;
         position_ff <= position_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - POS_OUT_W - 2)'(0), overflow_ff, position_ff, found_ff};

   // byte counter never passes its saturation point
   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= COUNT_LIMIT)
      else $error("byte counter above saturation limit");

   // an end-of-text request always leaves a result behind
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> rsp_valid_ff)
      else $error("end of text without result");

   // text state is cleared after an end-of-text request
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (bytes_seen_ff == '0) && !first_hit_ff && !last_hit_ff)
      else $error("text state not cleared");

   // a recorded hit needs at least one byte seen
   a_hit_needs_bytes: assert property (@(posedge clock) disable iff (reset)
      (first_hit_ff || last_hit_ff) |-> (bytes_seen_ff != '0))
      else $error("hit recorded on empty text");

endmodule : substring_position_matcher_unit

`default_nettype wire
